>>> rtl/core/avc_pkg.sv
// Shared constants and types of the artificial viscosity cell datapath.
package avc_pkg;

  // Fixed point format of every Q field.
  localparam int FracBits = 16;

  // Widths of the item fields and of the wide intermediates.
  localparam int QW      = 31;              // unsigned Q field
  localparam int UW      = 32;              // signed velocity field
  localparam int ProdW   = 2 * QW;          // product of two Q fields
  localparam int NumSW   = ProdW + FracBits; // sound speed dividend
  localparam int TermW   = ProdW + QW + 1;  // r^2 * |u|
  localparam int DivNW   = 96;              // divider dividend
  localparam int DivDW   = 64;              // divider divisor
  localparam int ClipW   = 62;              // clipped intermediates
  localparam int DivSteps = ClipW;          // one quotient bit per stage
  localparam int SqSteps  = ClipW / 2;      // one root bit per stage
  localparam int A2W     = ProdW - FracBits; // a^2 in Q form
  localparam int SatBit  = QW + FracBits;   // first bit that saturates q0
  localparam int ClW     = SatBit + 1;      // clamped operand width
  localparam int CfgIdxW = 2;

  localparam logic [ClipW-1:0] Cap62   = {ClipW{1'b1}};
  localparam logic [QW-1:0]    QMax    = {QW{1'b1}};
  localparam logic [QW-1:0]    ViscRst = QW'(1) << FracBits;

  typedef enum logic [CfgIdxW-1:0] {
    RegViscCoeff  = 2'd0,
    RegOnsetRatio = 2'd1
  } avc_reg_e;

  // Per-item flags and operands that ride along with the division.
  typedef struct packed {
    logic          bad;   // zero density or zero radius sum
    logic          neg;   // compression rate is negative
    logic [QW-1:0] dens;
  } avc_side_t;

  // What rides along with the square root.
  typedef struct packed {
    avc_side_t        side;
    logic [ClipW-1:0] dvmag;
  } avc_mid_t;

endpackage

>>> rtl/core/avc_front.sv
// Front stages: products, interface terms, signed difference and divisor.
module avc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [avc_pkg::QW-1:0]   gamma_i,
  input  logic [avc_pkg::QW-1:0]   pressure_i,
  input  logic [avc_pkg::QW-1:0]   density_i,
  input  logic [avc_pkg::QW-1:0]   r_outer_i,
  input  logic [avc_pkg::QW-1:0]   r_inner_i,
  input  logic [avc_pkg::UW-1:0]   u_outer_i,
  input  logic [avc_pkg::UW-1:0]   u_inner_i,
  output logic                     valid_o,
  output logic [avc_pkg::NumSW-1:0] num_s_o,
  output logic [avc_pkg::DivNW-1:0] num_d_o,
  output logic [avc_pkg::DivDW-1:0] den_d_o,
  output avc_pkg::avc_side_t       side_o
);
  import avc_pkg::*;

  logic [4:0] v_q;

  // stage 1
  logic [ProdW-1:0] gp1_q, ro2_q, ri2_q;
  logic [QW:0]      sum1_q;
  logic [UW-1:0]    muo1_q, mui1_q;
  logic             so1_q, si1_q;
  logic [QW-1:0]    dens1_q;
  logic [UW-1:0]    muo_d, mui_d;

  // stage 2
  logic [DivDW-1:0] den2_q;
  logic [ProdW:0]   ppoh_q, ppol_q, ppih_q, ppil_q;
  logic             so2_q, si2_q, bad2_q;
  logic [ProdW-1:0] gp2_q;
  logic [QW-1:0]    dens2_q;

  // stage 3
  logic [TermW-1:0] to3_q, ti3_q;
  logic [DivDW-1:0] den3_q;
  logic             so3_q, si3_q, bad3_q;
  logic [ProdW-1:0] gp3_q;
  logic [QW-1:0]    dens3_q;

  // stage 4
  logic [TermW:0]   s4_q;
  logic [DivNW-1:0] d4_q;
  logic [DivDW-1:0] den4_q;
  logic             so4_q, si4_q, bad4_q;
  logic [ProdW-1:0] gp4_q;
  logic [QW-1:0]    dens4_q;

  // stage 5
  logic [TermW-1:0] mag5_q;
  logic             neg5_q, bad5_q;
  logic [DivDW-1:0] den5_q;
  logic [ProdW-1:0] gp5_q;
  logic [QW-1:0]    dens5_q;

  logic [DivNW-1:0] dabs;
  logic             dneg;
  logic [TermW-1:0] mag_d;
  logic             neg_d;

  assign muo_d = u_outer_i[UW-1] ? (UW'(0) - u_outer_i) : u_outer_i;
  assign mui_d = u_inner_i[UW-1] ? (UW'(0) - u_inner_i) : u_inner_i;

  // pick the sign and magnitude of ro^2*uo - ri^2*ui
  assign dneg = d4_q[DivNW-1];
  assign dabs = dneg ? (DivNW'(0) - d4_q) : d4_q;
  always_comb begin
    case ({so4_q, si4_q})
      2'b00: begin
        neg_d = dneg;
        mag_d = dabs[TermW-1:0];
      end
      2'b11: begin
        neg_d = !dneg && (d4_q != '0);
        mag_d = dabs[TermW-1:0];
      end
      2'b01: begin
        neg_d = 1'b0;
        mag_d = s4_q[TermW-1:0];
      end
      2'b10: begin
        neg_d = (s4_q != '0);
        mag_d = s4_q[TermW-1:0];
      end
      default: begin
        neg_d = 1'b0;
        mag_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gp1_q   <= ProdW'(gamma_i) * ProdW'(pressure_i);
      ro2_q   <= ProdW'(r_outer_i) * ProdW'(r_outer_i);
      ri2_q   <= ProdW'(r_inner_i) * ProdW'(r_inner_i);
      sum1_q  <= (QW+1)'(r_outer_i) + (QW+1)'(r_inner_i);
      muo1_q  <= muo_d;
      mui1_q  <= mui_d;
      so1_q   <= u_outer_i[UW-1];
      si1_q   <= u_inner_i[UW-1];
      dens1_q <= density_i;

      den2_q  <= DivDW'(sum1_q) * DivDW'(sum1_q);
      ppoh_q  <= (ProdW+1)'(ro2_q[ProdW-1:QW]) * (ProdW+1)'(muo1_q);
      ppol_q  <= (ProdW+1)'(ro2_q[QW-1:0]) * (ProdW+1)'(muo1_q);
      ppih_q  <= (ProdW+1)'(ri2_q[ProdW-1:QW]) * (ProdW+1)'(mui1_q);
      ppil_q  <= (ProdW+1)'(ri2_q[QW-1:0]) * (ProdW+1)'(mui1_q);
      so2_q   <= so1_q;
      si2_q   <= si1_q;
      bad2_q  <= (dens1_q == '0) || (sum1_q == '0);
      gp2_q   <= gp1_q;
      dens2_q <= dens1_q;

      to3_q   <= TermW'({ppoh_q, {QW{1'b0}}}) + TermW'(ppol_q);
      ti3_q   <= TermW'({ppih_q, {QW{1'b0}}}) + TermW'(ppil_q);
      den3_q  <= den2_q;
      so3_q   <= so2_q;
      si3_q   <= si2_q;
      bad3_q  <= bad2_q;
      gp3_q   <= gp2_q;
      dens3_q <= dens2_q;

      s4_q    <= (TermW+1)'(to3_q) + (TermW+1)'(ti3_q);
      d4_q    <= DivNW'(to3_q) - DivNW'(ti3_q);
      den4_q  <= den3_q;
      so4_q   <= so3_q;
      si4_q   <= si3_q;
      bad4_q  <= bad3_q;
      gp4_q   <= gp3_q;
      dens4_q <= dens3_q;

      mag5_q  <= mag_d;
      neg5_q  <= neg_d;
      bad5_q  <= bad4_q;
      den5_q  <= den4_q;
      gp5_q   <= gp4_q;
      dens5_q <= dens4_q;
    end
  end

  assign valid_o = v_q[4];
  assign num_s_o = {gp5_q, {FracBits{1'b0}}};
  // the factor four stands in for halving the radius sum
  assign num_d_o = DivNW'({mag5_q, 2'b00});
  assign den_d_o = den5_q;
  assign side_o  = '{bad: bad5_q, neg: neg5_q, dens: dens5_q};

endmodule

>>> rtl/core/avc_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, clipped quotient.
module avc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [avc_pkg::NumSW-1:0]  num_s_i,
  input  logic [avc_pkg::QW-1:0]     den_s_i,
  input  logic [avc_pkg::DivNW-1:0]  num_d_i,
  input  logic [avc_pkg::DivDW-1:0]  den_d_i,
  input  avc_pkg::avc_side_t         side_i,
  output logic                       valid_o,
  output logic [avc_pkg::ClipW-1:0]  q_s_o,
  output logic [avc_pkg::ClipW-1:0]  q_d_o,
  output avc_pkg::avc_side_t         side_o
);
  import avc_pkg::*;

  typedef struct packed {
    logic             ovf;
    logic [DivDW-1:0] rem;
    logic [ClipW-1:0] nq;   // dividend bits shift out, quotient bits shift in
    logic [DivDW-1:0] dv;
  } lane_t;

  function automatic lane_t div_load(logic [DivNW-1:0] n, logic [DivDW-1:0] d);
    lane_t l;
    l.ovf = DivDW'(n[DivNW-1:ClipW]) >= d;
    l.rem = DivDW'(n[DivNW-1:ClipW]);
    l.nq  = n[ClipW-1:0];
    l.dv  = d;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l);
    logic [DivDW:0] r2;
    logic           ge;
    lane_t          o;
    r2    = {l.rem, l.nq[ClipW-1]};
    ge    = r2 >= {1'b0, l.dv};
    o     = l;
    o.rem = ge ? DivDW'(r2 - {1'b0, l.dv}) : r2[DivDW-1:0];
    o.nq  = {l.nq[ClipW-2:0], ge};
    return o;
  endfunction

  logic [DivSteps:0] v_q;
  lane_t             ls_q [DivSteps+1];
  lane_t             ld_q [DivSteps+1];
  avc_side_t         sd_q [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ls_q[0] <= div_load(DivNW'(num_s_i), DivDW'(den_s_i));
      ld_q[0] <= div_load(num_d_i, den_d_i);
      sd_q[0] <= side_i;
    end
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ls_q[g+1] <= div_step(ls_q[g]);
        ld_q[g+1] <= div_step(ld_q[g]);
        sd_q[g+1] <= sd_q[g];
      end
    end
  end

  assign valid_o = v_q[DivSteps];
  assign q_s_o   = ls_q[DivSteps].ovf ? Cap62 : ls_q[DivSteps].nq;
  assign q_d_o   = ld_q[DivSteps].ovf ? Cap62 : ld_q[DivSteps].nq;
  assign side_o  = sd_q[DivSteps];

endmodule

>>> rtl/core/avc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module avc_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic [avc_pkg::ClipW-1:0] x_i,
  input  avc_pkg::avc_mid_t         mid_i,
  output logic                      valid_o,
  output logic [avc_pkg::QW-1:0]    root_o,
  output avc_pkg::avc_mid_t         mid_o
);
  import avc_pkg::*;

  logic [SqSteps:0] v_q;
  logic [ClipW-1:0] x_q   [SqSteps+1];
  logic [ClipW-1:0] res_q [SqSteps+1];
  avc_mid_t         mid_q [SqSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[SqSteps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x_i;
      res_q[0] <= '0;
      mid_q[0] <= mid_i;
    end
  end

  for (genvar g = 0; g < SqSteps; g++) begin : g_step
    localparam logic [ClipW-1:0] Bit = ClipW'(1) << (2 * (SqSteps - 1 - g));
    logic [ClipW:0] trial;
    logic           ge;

    assign trial = {1'b0, res_q[g]} + {1'b0, Bit};
    assign ge    = {1'b0, x_q[g]} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]   <= ge ? (x_q[g] - trial[ClipW-1:0]) : x_q[g];
        res_q[g+1] <= ge ? ((res_q[g] >> 1) + Bit) : (res_q[g] >> 1);
        mid_q[g+1] <= mid_q[g];
      end
    end
  end

  assign valid_o = v_q[SqSteps];
  assign root_o  = res_q[SqSteps][QW-1:0];
  assign mid_o   = mid_q[SqSteps];

endmodule

>>> rtl/core/avc_back.sv
// Back stages: threshold, compression margin, coefficient product and saturation.
module avc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  logic [avc_pkg::QW-1:0]   c_i,
  input  avc_pkg::avc_mid_t        mid_i,
  input  logic [avc_pkg::A2W-1:0]  a2_i,
  input  logic [avc_pkg::QW-1:0]   onset_i,
  output logic                     valid_o,
  output logic [avc_pkg::QW-1:0]   q0_o,
  output logic                     sat_o
);
  import avc_pkg::*;

  localparam int ALo = A2W / 2;
  localparam int AHi = A2W - ALo;
  localparam int TfW = A2W + QW;
  localparam int TW  = TfW - FracBits;
  localparam int HW  = ClW / 2;
  localparam int PW  = 2 * ClW;
  localparam logic [ClW-1:0] Clamp = ClW'(1) << SatBit;

  logic [5:0] v_q;

  logic [ProdW-1:0]    thrp1_q;
  logic [AHi+QW-1:0]   pth1_q;
  logic [ALo+QW-1:0]   ptl1_q;
  logic [ClipW-1:0]    dv1_q;
  logic                neg1_q, bad1_q;

  logic [ClipW-1:0]    m2_q;
  logic                cmp2_q, bad2_q;
  logic [ClW-1:0]      tc2_q;

  logic                big3_q, cmp3_q, bad3_q;
  logic [2*UW-1:0]     msq3_q;
  logic [ClW-1:0]      tc3_q;

  logic [ClW-1:0]      mc4_q, tc4_q;
  logic                cmp4_q, bad4_q;

  logic [ClW-1:0]      phh5_q, phl5_q, plh5_q, pll5_q;
  logic                cmp5_q, bad5_q;

  logic [PW-1:0]       p6_q;
  logic                cmp6_q, bad6_q;

  logic [ClipW:0]      diff;
  logic [QW+FracBits-1:0] thr;
  logic [TfW-1:0]      tful;
  logic [TW-1:0]       tval;
  logic [2*UW-1:0]     mmf;
  logic                sat_p;

  assign thr  = (QW+FracBits)'(thrp1_q >> FracBits);
  assign diff = (ClipW+1)'(dv1_q) - (ClipW+1)'(thr);
  assign tful = TfW'({pth1_q, {ALo{1'b0}}}) + TfW'(ptl1_q);
  assign tval = TW'(tful >> FracBits);
  assign mmf  = msq3_q >> FracBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      thrp1_q <= ProdW'(onset_i) * ProdW'(c_i);
      pth1_q  <= (AHi+QW)'(a2_i[A2W-1:ALo]) * (AHi+QW)'(mid_i.side.dens);
      ptl1_q  <= (ALo+QW)'(a2_i[ALo-1:0]) * (ALo+QW)'(mid_i.side.dens);
      dv1_q   <= mid_i.dvmag;
      neg1_q  <= mid_i.side.neg;
      bad1_q  <= mid_i.side.bad;

      // compressing only when the rate lies below minus the threshold
      m2_q    <= diff[ClipW-1:0];
      cmp2_q  <= neg1_q && !diff[ClipW] && (diff[ClipW-1:0] != '0);
      bad2_q  <= bad1_q;
      tc2_q   <= ((tval >> SatBit) != '0) ? Clamp : tval[ClW-1:0];

      big3_q  <= (m2_q >> UW) != '0;
      msq3_q  <= (2*UW)'(m2_q[UW-1:0]) * (2*UW)'(m2_q[UW-1:0]);
      tc3_q   <= tc2_q;
      cmp3_q  <= cmp2_q;
      bad3_q  <= bad2_q;

      // operands at or above the saturation point saturate alike once clamped
      mc4_q   <= (big3_q || ((mmf >> SatBit) != '0)) ? Clamp : mmf[ClW-1:0];
      tc4_q   <= tc3_q;
      cmp4_q  <= cmp3_q;
      bad4_q  <= bad3_q;

      phh5_q  <= ClW'(tc4_q[ClW-1:HW]) * ClW'(mc4_q[ClW-1:HW]);
      phl5_q  <= ClW'(tc4_q[ClW-1:HW]) * ClW'(mc4_q[HW-1:0]);
      plh5_q  <= ClW'(tc4_q[HW-1:0]) * ClW'(mc4_q[ClW-1:HW]);
      pll5_q  <= ClW'(tc4_q[HW-1:0]) * ClW'(mc4_q[HW-1:0]);
      cmp5_q  <= cmp4_q;
      bad5_q  <= bad4_q;

      p6_q    <= PW'({phh5_q, {ClW{1'b0}}}) + PW'({phl5_q, {HW{1'b0}}})
               + PW'({plh5_q, {HW{1'b0}}}) + PW'(pll5_q);
      cmp6_q  <= cmp5_q;
      bad6_q  <= bad5_q;
    end
  end

  assign sat_p   = (p6_q >> SatBit) != '0;
  assign valid_o = v_q[5];

  always_comb begin
    if (bad6_q) begin
      q0_o  = '0;
      sat_o = 1'b1;
    end else if (!cmp6_q) begin
      q0_o  = '0;
      sat_o = 1'b0;
    end else if (sat_p) begin
      q0_o  = QMax;
      sat_o = 1'b1;
    end else begin
      q0_o  = p6_q[SatBit-1:FracBits];
      sat_o = 1'b0;
    end
  end

endmodule

>>> rtl/core/artificial_viscosity_cell_unit.sv
// Artificial viscosity of one radial cell: pipeline, configuration and output buffer.
//
// Input channel (in_valid_i/in_ready_o) takes one cell word: gamma, pressure,
// density, both interface radii and both interface velocities. Output channel
// (out_valid_o/out_ready_i) gives one word per cell, in order: q0 and the
// saturated flag. Cells are independent, so a new word enters every cycle
// while in_ready_o is high. From accept to out_valid_o a word passes 5 front
// stages, 63 stages of the two-lane divider (a load stage, then one quotient bit
// each), 32 stages of the square root (a load stage, then one root bit each),
// 6 back stages and the output register.
// Throughput is one word per cycle while the receiver keeps up.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered;
// write while no cell is in flight. Unknown indexes are ignored.
// Reset empties the pipeline and loads a = 1.0 and a zero onset ratio.
// When the receiver stalls, the output word holds and one more word parks in
// a skid register; then in_ready_o drops and the whole pipeline holds, so
// nothing is lost or repeated. in_ready_o depends on registers only.
module artificial_viscosity_cell_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [avc_pkg::QW-1:0]      gamma_i,
  input  logic [avc_pkg::QW-1:0]      pressure_i,
  input  logic [avc_pkg::QW-1:0]      density_i,
  input  logic [avc_pkg::QW-1:0]      r_outer_i,
  input  logic [avc_pkg::QW-1:0]      r_inner_i,
  input  logic [avc_pkg::UW-1:0]      u_outer_i,
  input  logic [avc_pkg::UW-1:0]      u_inner_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [avc_pkg::QW-1:0]      q0_o,
  output logic                        saturated_o,
  input  logic                        cfg_we_i,
  input  logic [avc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [avc_pkg::QW-1:0]      cfg_data_i
);
  import avc_pkg::*;

  logic [QW-1:0]  visc_q, onset_q;
  logic [A2W-1:0] a2_q;
  logic           en;

  logic              fv;
  logic [NumSW-1:0]  f_num_s;
  logic [DivNW-1:0]  f_num_d;
  logic [DivDW-1:0]  f_den_d;
  avc_side_t         f_side;

  logic              dv;
  logic [ClipW-1:0]  d_qs, d_qd;
  avc_side_t         d_side;
  avc_mid_t          d_mid;

  logic              sv;
  logic [QW-1:0]     s_root;
  avc_mid_t          s_mid;

  logic              bv;
  logic [QW-1:0]     b_q0;
  logic              b_sat;

  logic              out_v_q, skid_v_q;
  logic [QW-1:0]     out_q0_q, skid_q0_q;
  logic              out_sat_q, skid_sat_q;

  // whole pipeline advances while the skid register is free
  assign en         = !skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q  <= ViscRst;
      onset_q <= '0;
    end else if (cfg_we_i) begin
      case (avc_reg_e'(cfg_idx_i))
        RegViscCoeff:  visc_q  <= cfg_data_i;
        RegOnsetRatio: onset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a^2 in Q form, follows the register in the next cycle
  always_ff @(posedge clk_i) begin
    a2_q <= A2W'((ProdW'(visc_q) * ProdW'(visc_q)) >> FracBits);
  end

  avc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .gamma_i    (gamma_i),
    .pressure_i (pressure_i),
    .density_i  (density_i),
    .r_outer_i  (r_outer_i),
    .r_inner_i  (r_inner_i),
    .u_outer_i  (u_outer_i),
    .u_inner_i  (u_inner_i),
    .valid_o    (fv),
    .num_s_o    (f_num_s),
    .num_d_o    (f_num_d),
    .den_d_o    (f_den_d),
    .side_o     (f_side)
  );

  avc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (fv),
    .num_s_i    (f_num_s),
    .den_s_i    (f_side.dens),
    .num_d_i    (f_num_d),
    .den_d_i    (f_den_d),
    .side_i     (f_side),
    .valid_o    (dv),
    .q_s_o      (d_qs),
    .q_d_o      (d_qd),
    .side_o     (d_side)
  );

  assign d_mid = '{side: d_side, dvmag: d_qd};

  avc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (dv),
    .x_i        (d_qs),
    .mid_i      (d_mid),
    .valid_o    (sv),
    .root_o     (s_root),
    .mid_o      (s_mid)
  );

  avc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (sv),
    .c_i        (s_root),
    .mid_i      (s_mid),
    .a2_i       (a2_q),
    .onset_i    (onset_q),
    .valid_o    (bv),
    .q0_o       (b_q0),
    .sat_o      (b_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !out_ready_i) begin
      // hold the output word, park the next one
      if (en && bv) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= en && bv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !out_ready_i) begin
      if (en && bv) begin
        skid_q0_q  <= b_q0;
        skid_sat_q <= b_sat;
      end
    end else if (skid_v_q) begin
      out_q0_q  <= skid_q0_q;
      out_sat_q <= skid_sat_q;
    end else begin
      out_q0_q  <= b_q0;
      out_sat_q <= b_sat;
    end
  end

  assign out_valid_o = out_v_q;
  assign q0_o        = out_q0_q;
  assign saturated_o = out_sat_q;

endmodule
